[src/pbkdf_pkg.sv]
// Shared types, codes and constants for the PBKDF2 HMAC-SHA-512 engine.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package pbkdf_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [7:0]  state_t;
  typedef word_t [15:0] block_t;

  localparam logic [1:0] MODE_PW    = 2'd0;
  localparam logic [1:0] MODE_SALT  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [1:0] CFG_PW_LEN   = 2'd0;
  localparam logic [1:0] CFG_SALT_LEN = 2'd1;
  localparam logic [1:0] CFG_ITER     = 2'd2;

  localparam logic [31:0] ITER_RESET    = 32'd2048;
  localparam logic [7:0]  PAD_IN        = 8'h36;
  localparam logic [7:0]  PAD_OUT       = 8'h5c;
  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam logic [7:0]  BLOCK_INDEX_1 = 8'h01;
  // 128-byte key block plus 64-byte digest, in bits
  localparam logic [63:0] DIG_MSG_BITS  = 64'd1536;
  // salt plus index plus marker plus length fits one block up to this length
  localparam int          SALT_ONE_BLK_MAX = 107;
  localparam int          BLOCK_BYTES      = 128;

  localparam state_t SHA_IV = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  typedef enum logic [2:0] {
    INIT_IV, INIT_HW, INIT_CORE, INIT_IPAD, INIT_OPAD
  } init_sel_t;

  typedef enum logic [3:0] {
    BLK_BUF, BLK_FIN0, BLK_FIN1, BLK_KEY_IN, BLK_KEY_OUT,
    BLK_SALT0, BLK_SALT1, BLK_DIG_CORE, BLK_DIG_U
  } blk_sel_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_HW, DST_IPAD, DST_OPAD, DST_U1, DST_U
  } dest_t;

  typedef struct packed {
    logic      start;
    init_sel_t init_sel;
    blk_sel_t  blk_sel;
    dest_t     dest;
  } cmd_t;

  typedef struct packed {
    logic pw_ok;
    logic pos_last;
    logic pw_long;
    logic pos_hi;
    logic salt_two;
    logic core_done;
    logic more_rounds;
    logic last_k;
  } stat_t;

endpackage

`default_nettype wire

[src/pbkdf_ifs.sv]
// Request channel interfaces for the PBKDF2 engine: byte input and result output.
// No dependencies.
`default_nettype none

interface pbkdf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface pbkdf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output result_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input result_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

[src/pbkdf_sha_core.sv]
// SHA-512 compression unit: one round per cycle, rolling 16-word schedule.
// Depends on pbkdf_pkg.
`default_nettype none

module pbkdf_sha_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start_i,
  input  pbkdf_pkg::state_t  init_i,
  input  pbkdf_pkg::block_t  blk_i,
  output logic               done_o,
  output pbkdf_pkg::state_t  dig_o
);

  localparam logic [6:0] LAST_RND = 7'd79;

  localparam logic [63:0] K_TAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic              busy_r, fin_r, done_r;
  logic [6:0]        rnd_r;
  pbkdf_pkg::block_t w_r;
  pbkdf_pkg::state_t v_r, h_r, v_nxt;
  logic [63:0]       s1, ch, t1, s0, mj, t2, w_new;

  always_comb begin
    s1 = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + K_TAB[rnd_r] + w_r[0];
    s0 = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
    w_new = w_r[0] + (rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7)) + w_r[9]
          + (rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6));
    v_nxt[7] = v_r[6];
    v_nxt[6] = v_r[5];
    v_nxt[5] = v_r[4];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[3] = v_r[2];
    v_nxt[2] = v_r[1];
    v_nxt[1] = v_r[0];
    v_nxt[0] = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 7'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= busy_r && (rnd_r == LAST_RND);
      if (start_i) begin
        busy_r <= 1'b1;
        rnd_r  <= 7'd0;
      end else if (busy_r) begin
        if (rnd_r == LAST_RND) begin
          busy_r <= 1'b0;
        end else begin
          rnd_r <= rnd_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      h_r <= init_i;
      v_r <= init_i;
      w_r <= blk_i;
    end else if (busy_r) begin
      v_r <= v_nxt;
      for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
      w_r[15] <= w_new;
    end else if (fin_r) begin
      for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
    end
  end

  assign done_o = done_r;
  assign dig_o  = h_r;

endmodule

`default_nettype wire

[src/pbkdf_dp.sv]
// Datapath: byte buffers, padded key states, U and accumulator, block builder.
// Depends on pbkdf_pkg and pbkdf_sha_core.
`default_nettype none

module pbkdf_dp #(
  parameter int MAX_SALT_BYTES = 128
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  input  wire                in_fire,
  input  wire  [1:0]         in_mode,
  input  wire  [7:0]         in_byte,
  input  wire                out_fire,
  input  pbkdf_pkg::cmd_t    cmd,
  output pbkdf_pkg::stat_t   stat,
  output logic [63:0]        result_word,
  output logic [2:0]         word_index,
  output logic               last_word
);

  localparam int SALT_AW = (MAX_SALT_BYTES > 1) ? $clog2(MAX_SALT_BYTES) : 1;
  localparam int SALT_CW = $clog2(MAX_SALT_BYTES + 1);

  logic [15:0]         plen_r;
  logic [7:0]          slen_r;
  logic [31:0]         iters_r;
  logic [15:0]         pw_cnt_r;
  logic [SALT_CW-1:0]  salt_cnt_r;
  logic [31:0]         rnd_r;
  logic [2:0]          k_r;
  pbkdf_pkg::dest_t    dest_r;
  logic [7:0]          buf_r  [pbkdf_pkg::BLOCK_BYTES];
  logic [7:0]          salt_r [MAX_SALT_BYTES];
  pbkdf_pkg::state_t   hw_r, ipad_r, opad_r, u_r, acc_r;

  logic                core_done;
  pbkdf_pkg::state_t   core_dig, init_c;
  pbkdf_pkg::block_t   blk_c;

  logic                pw_ok, salt_ok, pw_long, salt_two;
  logic [6:0]          pos;
  logic [8:0]          s9, salt_sum;
  logic [63:0]         len_pw, len_salt;
  logic [31:0]         iters_eff, rnd_next;

  assign pos      = pw_cnt_r[6:0];
  assign pw_ok    = pw_cnt_r < plen_r;
  assign salt_ok  = (9'(salt_cnt_r) < 9'(slen_r))
                 && (salt_cnt_r < SALT_CW'(MAX_SALT_BYTES));
  assign pw_long  = pw_cnt_r > 16'(pbkdf_pkg::BLOCK_BYTES);
  assign s9       = 9'(salt_cnt_r);
  assign salt_two = s9 > 9'(pbkdf_pkg::SALT_ONE_BLK_MAX);
  assign salt_sum = s9 + 9'd132;
  assign len_pw   = {45'd0, pw_cnt_r, 3'd0};
  assign len_salt = {52'd0, salt_sum, 3'd0};
  assign iters_eff = (iters_r == 32'd0) ? 32'd1 : iters_r;
  assign rnd_next  = (dest_r == pbkdf_pkg::DST_U1) ? 32'd1 : rnd_r + 32'd1;

  always_comb begin
    stat.pw_ok       = pw_ok;
    stat.pos_last    = (pos == 7'd127);
    stat.pw_long     = pw_long;
    stat.pos_hi      = (pos >= 7'd112);
    stat.salt_two    = salt_two;
    stat.core_done   = core_done;
    stat.more_rounds = rnd_next < iters_eff;
    stat.last_k      = (k_r == 3'd7);
  end

  always_comb begin
    case (cmd.init_sel)
      pbkdf_pkg::INIT_IV:   init_c = pbkdf_pkg::SHA_IV;
      pbkdf_pkg::INIT_HW:   init_c = hw_r;
      pbkdf_pkg::INIT_CORE: init_c = core_dig;
      pbkdf_pkg::INIT_IPAD: init_c = ipad_r;
      pbkdf_pkg::INIT_OPAD: init_c = opad_r;
      default:              init_c = pbkdf_pkg::SHA_IV;
    endcase
  end

  always_comb begin
    logic [7:0] bt, kb, db;
    logic [8:0] p9;
    blk_c = '0;
    for (int q = 0; q < pbkdf_pkg::BLOCK_BYTES; q++) begin
      if (pw_long) begin
        kb = (q < 64) ? hw_r[q >> 3][8*(7 - (q & 7)) +: 8] : 8'd0;
      end else begin
        kb = (16'(q) < pw_cnt_r) ? buf_r[q] : 8'd0;
      end
      if (cmd.blk_sel == pbkdf_pkg::BLK_DIG_U) begin
        db = (q < 64) ? u_r[q >> 3][8*(7 - (q & 7)) +: 8] : 8'd0;
      end else begin
        db = (q < 64) ? core_dig[q >> 3][8*(7 - (q & 7)) +: 8] : 8'd0;
      end
      p9 = (cmd.blk_sel == pbkdf_pkg::BLK_SALT1) ? 9'(q + 128) : 9'(q);
      case (cmd.blk_sel)
        pbkdf_pkg::BLK_BUF: bt = buf_r[q];
        pbkdf_pkg::BLK_FIN0: begin
          if (7'(q) < pos)       bt = buf_r[q];
          else if (7'(q) == pos) bt = pbkdf_pkg::PAD_MARK;
          else                   bt = 8'd0;
          if (pos < 7'd112 && q >= 120) bt = len_pw[8*(127 - q) +: 8];
        end
        pbkdf_pkg::BLK_FIN1: bt = (q >= 120) ? len_pw[8*(127 - q) +: 8] : 8'd0;
        pbkdf_pkg::BLK_KEY_IN:  bt = kb ^ pbkdf_pkg::PAD_IN;
        pbkdf_pkg::BLK_KEY_OUT: bt = kb ^ pbkdf_pkg::PAD_OUT;
        pbkdf_pkg::BLK_SALT0, pbkdf_pkg::BLK_SALT1: begin
          if (p9 < s9)                 bt = salt_r[SALT_AW'(q)];
          else if (p9 == s9 + 9'd3)    bt = pbkdf_pkg::BLOCK_INDEX_1;
          else if (p9 == s9 + 9'd4)    bt = pbkdf_pkg::PAD_MARK;
          else                         bt = 8'd0;
          if (q >= 120 && (cmd.blk_sel == pbkdf_pkg::BLK_SALT1 || !salt_two))
            bt = len_salt[8*(127 - q) +: 8];
        end
        pbkdf_pkg::BLK_DIG_CORE, pbkdf_pkg::BLK_DIG_U: begin
          if (q < 64)       bt = db;
          else if (q == 64) bt = pbkdf_pkg::PAD_MARK;
          else if (q >= 120) bt = pbkdf_pkg::DIG_MSG_BITS[8*(127 - q) +: 8];
          else              bt = 8'd0;
        end
        default: bt = 8'd0;
      endcase
      blk_c[q >> 3][8*(7 - (q & 7)) +: 8] = bt;
    end
  end

  pbkdf_sha_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd.start),
    .init_i  (init_c),
    .blk_i   (blk_c),
    .done_o  (core_done),
    .dig_o   (core_dig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r     <= 16'd0;
      slen_r     <= 8'd0;
      iters_r    <= pbkdf_pkg::ITER_RESET;
      pw_cnt_r   <= 16'd0;
      salt_cnt_r <= '0;
      k_r        <= 3'd0;
      dest_r     <= pbkdf_pkg::DST_NONE;
      hw_r       <= pbkdf_pkg::SHA_IV;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pbkdf_pkg::CFG_PW_LEN:   plen_r  <= cfg_data[15:0];
          pbkdf_pkg::CFG_SALT_LEN: slen_r  <= cfg_data[7:0];
          pbkdf_pkg::CFG_ITER:     iters_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && in_mode == pbkdf_pkg::MODE_PW && pw_ok)
        pw_cnt_r <= pw_cnt_r + 16'd1;
      if (in_fire && in_mode == pbkdf_pkg::MODE_SALT && salt_ok)
        salt_cnt_r <= salt_cnt_r + SALT_CW'(1);
      if (cmd.start) dest_r <= cmd.dest;
      if (core_done && dest_r == pbkdf_pkg::DST_HW) hw_r <= core_dig;
      if (out_fire) begin
        k_r <= k_r + 3'd1;
        if (k_r == 3'd7) begin
          pw_cnt_r   <= 16'd0;
          salt_cnt_r <= '0;
          hw_r       <= pbkdf_pkg::SHA_IV;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == pbkdf_pkg::MODE_PW && pw_ok) buf_r[pos] <= in_byte;
    if (in_fire && in_mode == pbkdf_pkg::MODE_SALT && salt_ok)
      salt_r[salt_cnt_r[SALT_AW-1:0]] <= in_byte;
    if (core_done) begin
      case (dest_r)
        pbkdf_pkg::DST_IPAD: ipad_r <= core_dig;
        pbkdf_pkg::DST_OPAD: opad_r <= core_dig;
        pbkdf_pkg::DST_U1: begin
          u_r   <= core_dig;
          acc_r <= core_dig;
          rnd_r <= 32'd1;
        end
        pbkdf_pkg::DST_U: begin
          u_r   <= core_dig;
          acc_r <= acc_r ^ core_dig;
          rnd_r <= rnd_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  assign result_word = acc_r[k_r];
  assign word_index  = k_r;
  assign last_word   = (k_r == 3'd7);

endmodule

`default_nettype wire

[src/pbkdf_ctrl.sv]
// Controller: sequences byte loads, key setup, HMAC rounds and result output.
// Depends on pbkdf_pkg.
`default_nettype none

module pbkdf_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_fire,
  input  wire  [1:0]        in_mode,
  input  wire               out_fire,
  input  pbkdf_pkg::stat_t  stat,
  output pbkdf_pkg::cmd_t   cmd,
  output logic              in_ready,
  output logic              out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_PW, S_FIN0, S_FIN1, S_IPAD, S_OPAD,
    S_UIN0, S_UIN1, S_UOUT, S_ITIN, S_ITOUT, S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  pbkdf_pkg::cmd_t cmd_r, cmd_nxt;

  function automatic pbkdf_pkg::cmd_t job(input pbkdf_pkg::init_sel_t i,
                                          input pbkdf_pkg::blk_sel_t b,
                                          input pbkdf_pkg::dest_t d);
    pbkdf_pkg::cmd_t c;
    c.start    = 1'b1;
    c.init_sel = i;
    c.blk_sel  = b;
    c.dest     = d;
    return c;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cmd_nxt.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode == pbkdf_pkg::MODE_PW && stat.pw_ok && stat.pos_last) begin
            cmd_nxt   = job(pbkdf_pkg::INIT_HW, pbkdf_pkg::BLK_BUF, pbkdf_pkg::DST_HW);
            state_nxt = S_PW;
          end else if (in_mode == pbkdf_pkg::MODE_START) begin
            if (stat.pw_long) begin
              cmd_nxt   = job(pbkdf_pkg::INIT_HW, pbkdf_pkg::BLK_FIN0,
                              stat.pos_hi ? pbkdf_pkg::DST_NONE : pbkdf_pkg::DST_HW);
              state_nxt = S_FIN0;
            end else begin
              cmd_nxt   = job(pbkdf_pkg::INIT_IV, pbkdf_pkg::BLK_KEY_IN, pbkdf_pkg::DST_IPAD);
              state_nxt = S_IPAD;
            end
          end
        end
      end
      S_PW: if (stat.core_done) state_nxt = S_IDLE;
      S_FIN0: begin
        if (stat.core_done) begin
          if (stat.pos_hi) begin
            cmd_nxt   = job(pbkdf_pkg::INIT_CORE, pbkdf_pkg::BLK_FIN1, pbkdf_pkg::DST_HW);
            state_nxt = S_FIN1;
          end else begin
            cmd_nxt   = job(pbkdf_pkg::INIT_IV, pbkdf_pkg::BLK_KEY_IN, pbkdf_pkg::DST_IPAD);
            state_nxt = S_IPAD;
          end
        end
      end
      S_FIN1: begin
        if (stat.core_done) begin
          cmd_nxt   = job(pbkdf_pkg::INIT_IV, pbkdf_pkg::BLK_KEY_IN, pbkdf_pkg::DST_IPAD);
          state_nxt = S_IPAD;
        end
      end
      S_IPAD: begin
        if (stat.core_done) begin
          cmd_nxt   = job(pbkdf_pkg::INIT_IV, pbkdf_pkg::BLK_KEY_OUT, pbkdf_pkg::DST_OPAD);
          state_nxt = S_OPAD;
        end
      end
      S_OPAD: begin
        if (stat.core_done) begin
          cmd_nxt   = job(pbkdf_pkg::INIT_IPAD, pbkdf_pkg::BLK_SALT0, pbkdf_pkg::DST_NONE);
          state_nxt = S_UIN0;
        end
      end
      S_UIN0: begin
        if (stat.core_done) begin
          if (stat.salt_two) begin
            cmd_nxt   = job(pbkdf_pkg::INIT_CORE, pbkdf_pkg::BLK_SALT1, pbkdf_pkg::DST_NONE);
            state_nxt = S_UIN1;
          end else begin
            cmd_nxt   = job(pbkdf_pkg::INIT_OPAD, pbkdf_pkg::BLK_DIG_CORE, pbkdf_pkg::DST_U1);
            state_nxt = S_UOUT;
          end
        end
      end
      S_UIN1: begin
        if (stat.core_done) begin
          cmd_nxt   = job(pbkdf_pkg::INIT_OPAD, pbkdf_pkg::BLK_DIG_CORE, pbkdf_pkg::DST_U1);
          state_nxt = S_UOUT;
        end
      end
      S_UOUT, S_ITOUT: begin
        if (stat.core_done) begin
          if (stat.more_rounds) begin
            cmd_nxt   = job(pbkdf_pkg::INIT_IPAD, pbkdf_pkg::BLK_DIG_U, pbkdf_pkg::DST_NONE);
            state_nxt = S_ITIN;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_ITIN: begin
        if (stat.core_done) begin
          cmd_nxt   = job(pbkdf_pkg::INIT_OPAD, pbkdf_pkg::BLK_DIG_CORE, pbkdf_pkg::DST_U);
          state_nxt = S_ITOUT;
        end
      end
      S_EMIT: if (out_fire && stat.last_k) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cmd_r.start    <= 1'b0;
      cmd_r.init_sel <= pbkdf_pkg::INIT_IV;
      cmd_r.blk_sel  <= pbkdf_pkg::BLK_BUF;
      cmd_r.dest     <= pbkdf_pkg::DST_NONE;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign cmd       = cmd_r;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

endmodule

`default_nettype wire

[src/pbkdf2_hmac_sha512_engine.sv]
// PBKDF2 HMAC-SHA-512 engine, first 64-byte block. Depends on pbkdf_pkg, pbkdf_ifs,
// pbkdf_ctrl and pbkdf_dp. Byte requests are taken without holding input off, but a password
// byte that closes a 128-byte block holds input off for one compression (one SHA round a cycle).
// A start request takes (2 + 2*iterations, plus one for a salt over 107 bytes, plus one or
// two for a password over 128 bytes) compressions, then eight result words.
// Synchronous active-low reset clears counters, sets registers to defaults and the hash to IV.
`default_nettype none

module pbkdf2_hmac_sha512_engine #(
  parameter int MAX_SALT_BYTES = 128
) (
  input  wire          clk,
  input  wire          rst_n,
  pbkdf_in_if.sink     in_ch,
  pbkdf_out_if.source  out_ch,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [31:0]  cfg_data
);

  pbkdf_pkg::cmd_t  cmd;
  pbkdf_pkg::stat_t stat;
  logic             in_ready, out_valid, in_fire, out_fire;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_valid && out_ch.ready;

  pbkdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_mode   (in_ch.mode),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  pbkdf_dp #(.MAX_SALT_BYTES(MAX_SALT_BYTES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .in_mode     (in_ch.mode),
    .in_byte     (in_ch.data_byte),
    .out_fire    (out_fire),
    .cmd         (cmd),
    .stat        (stat),
    .result_word (out_ch.result_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output both open");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ch.last_word |-> out_ch.word_index == 3'd7)
    else $error("last word flag at wrong index");
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_word |=> in_ready && !out_valid)
    else $error("not idle after final word");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !in_ready && !out_valid)
    else $error("compression launched while idle or emitting");
`endif

endmodule

`default_nettype wire

[sim/pbkdf_tb_ifs.sv]
// Testbench view of the request channels: the RTL interfaces are reused as they are.
// Depends on pbkdf_pkg; holds only the shared result record type.
`default_nettype none

package pbkdf_tb_pkg;

  typedef struct {
    pbkdf_pkg::word_t word;
    logic [2:0]       index;
    logic             last;
  } dk_word_t;

endpackage

`default_nettype wire

[sim/tb.sv]
// Top-level testbench for pbkdf2_hmac_sha512_engine: drives byte, salt and start requests,
// writes the registers between sessions, and checks every result word against an in-bench
// SHA-512 / HMAC / PBKDF2 predictor. Depends on pbkdf_pkg, pbkdf_ifs and pbkdf_tb_pkg.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         SALT_CAP    = 128;
  localparam int         CYCLE_LIMIT = 1500000;
  localparam int         SETTLE      = 120;

  localparam logic [63:0] RK [0:79] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef logic [7:0] byte_buf_t [256];

  class kdf_scoreboard;
    logic [15:0]              pw_len;
    logic [7:0]               salt_cfg;
    logic [31:0]              iter_cnt;
    logic [7:0]               key_bytes [128];
    logic [7:0]               salt_bytes [SALT_CAP];
    pbkdf_pkg::state_t        run_hash;
    pbkdf_pkg::block_t        run_blk;
    pbkdf_pkg::state_t        ipad_st, opad_st;
    int unsigned              pw_cnt, salt_cnt;
    pbkdf_tb_pkg::dk_word_t   words_due [$];
    int                       errors;
    int                       words_seen;

    function new();
      pw_len   = '0;
      salt_cfg = '0;
      iter_cnt = pbkdf_pkg::ITER_RESET;
      errors   = 0;
      words_seen = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (key_bytes[i]) key_bytes[i] = '0;
      run_hash = pbkdf_pkg::SHA_IV;
      run_blk  = '0;
      pw_cnt   = 0;
      salt_cnt = 0;
    endfunction

    function pbkdf_pkg::word_t rotr(pbkdf_pkg::word_t x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function pbkdf_pkg::state_t sha_compress(pbkdf_pkg::state_t st, pbkdf_pkg::block_t blk);
      pbkdf_pkg::word_t w [80];
      pbkdf_pkg::word_t v [8];
      pbkdf_pkg::word_t t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++) begin
        w[i] = w[i-16] + (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-7]
             + (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6));
      end
      for (int i = 0; i < 8; i++) v[i] = st[i];
      for (int i = 0; i < 80; i++) begin
        t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
        t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) st[i] = st[i] + v[i];
      return st;
    endfunction

    function pbkdf_pkg::block_t pack_block(byte_buf_t b, int off);
      pbkdf_pkg::block_t blk;
      for (int i = 0; i < 16; i++)
        for (int j = 0; j < 8; j++) blk[i][63-8*j -: 8] = b[off + 8*i + j];
      return blk;
    endfunction

    // hash of len bytes following one already compressed 128-byte block
    function pbkdf_pkg::state_t hash_after_block(pbkdf_pkg::state_t init, byte_buf_t m,
                                                 int len);
      byte_buf_t         buff;
      int                nblk;
      logic [63:0]       bits;
      pbkdf_pkg::state_t st;
      foreach (buff[i]) buff[i] = (i < len) ? m[i] : 8'h00;
      buff[len] = pbkdf_pkg::PAD_MARK;
      nblk = (len + 17 <= pbkdf_pkg::BLOCK_BYTES) ? 1 : 2;
      bits = 64'(pbkdf_pkg::BLOCK_BYTES + len) * 8;
      for (int i = 0; i < 8; i++)
        buff[nblk*pbkdf_pkg::BLOCK_BYTES - 8 + i] = bits[63-8*i -: 8];
      st = init;
      for (int i = 0; i < nblk; i++)
        st = sha_compress(st, pack_block(buff, i*pbkdf_pkg::BLOCK_BYTES));
      return st;
    endfunction

    function pbkdf_pkg::state_t hmac_of(byte_buf_t m, int len);
      pbkdf_pkg::state_t inner;
      byte_buf_t         ib;
      inner = hash_after_block(ipad_st, m, len);
      foreach (ib[i]) ib[i] = 8'h00;
      for (int i = 0; i < 64; i++) ib[i] = inner[i/8][63-8*(i%8) -: 8];
      return hash_after_block(opad_st, ib, 64);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        pbkdf_pkg::CFG_PW_LEN:   pw_len   = val[15:0];
        pbkdf_pkg::CFG_SALT_LEN: salt_cfg = val[7:0];
        pbkdf_pkg::CFG_ITER:     iter_cnt = val;
        default: ;
      endcase
    endfunction

    function void derive_key();
      byte_buf_t         key, pad, msg;
      pbkdf_pkg::state_t st, u, acc;
      pbkdf_pkg::block_t blk;
      int unsigned       pos, s, iters;
      foreach (key[i]) key[i] = 8'h00;
      if (pw_cnt > 128) begin
        pos = pw_cnt % 128;
        st  = run_hash;
        blk = run_blk;
        blk[pos/8][63-8*(pos%8) -: 8] = pbkdf_pkg::PAD_MARK;
        if (pos >= 112) begin
          st  = sha_compress(st, blk);
          blk = '0;
        end
        blk[14] = '0;
        blk[15] = 64'(pw_cnt) * 8;
        st = sha_compress(st, blk);
        for (int i = 0; i < 64; i++) key[i] = st[i/8][63-8*(i%8) -: 8];
      end else begin
        for (int i = 0; i < 128; i++) key[i] = key_bytes[i];
      end
      foreach (pad[i]) pad[i] = key[i] ^ pbkdf_pkg::PAD_IN;
      ipad_st = sha_compress(pbkdf_pkg::SHA_IV, pack_block(pad, 0));
      foreach (pad[i]) pad[i] = key[i] ^ pbkdf_pkg::PAD_OUT;
      opad_st = sha_compress(pbkdf_pkg::SHA_IV, pack_block(pad, 0));

      s = (salt_cnt > SALT_CAP) ? SALT_CAP : salt_cnt;
      foreach (msg[i]) msg[i] = (i < s) ? salt_bytes[i] : 8'h00;
      msg[s+3] = pbkdf_pkg::BLOCK_INDEX_1;
      u   = hmac_of(msg, s + 4);
      acc = u;
      iters = (iter_cnt == 0) ? 1 : iter_cnt;
      for (int unsigned r = 1; r < iters; r++) begin
        foreach (msg[i]) msg[i] = (i < 64) ? u[i/8][63-8*(i%8) -: 8] : 8'h00;
        u   = hmac_of(msg, 64);
        acc = acc ^ u;
      end
      for (int k = 0; k < 8; k++) words_due.push_back('{acc[k], 3'(k), k == 7});
    endfunction

    function void note_request(logic [1:0] mode, logic [7:0] b);
      int unsigned pos, cap;
      case (mode)
        pbkdf_pkg::MODE_PW: begin
          if (pw_cnt < pw_len && pw_cnt < 16'hFFFF) begin
            pos = pw_cnt % 128;
            if (pw_cnt < 128) key_bytes[pw_cnt] = b;
            run_blk[pos/8][63-8*(pos%8) -: 8] = b;
            if (pos == 127) begin
              run_hash = sha_compress(run_hash, run_blk);
              run_blk  = '0;
            end
            pw_cnt++;
          end
        end
        pbkdf_pkg::MODE_SALT: begin
          cap = (salt_cfg < SALT_CAP) ? salt_cfg : SALT_CAP;
          if (salt_cnt < cap) begin
            salt_bytes[salt_cnt] = b;
            salt_cnt++;
          end
        end
        pbkdf_pkg::MODE_START: begin
          derive_key();
          clear_stream();
        end
        default: ;
      endcase
    endfunction

    function void check_word(pbkdf_pkg::word_t w, logic [2:0] idx, logic last);
      pbkdf_tb_pkg::dk_word_t due;
      words_seen++;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h index %0d", w, idx);
        return;
      end
      due = words_due.pop_front();
      if (w !== due.word || idx !== due.index || last !== due.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                   due.word, due.index, due.last, w, idx, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  pbkdf_in_if  in_ch ();
  pbkdf_out_if out_ch ();

  pbkdf2_hmac_sha512_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kdf_scoreboard dk_sb = new();
  int  send_gap_pct  = 29;
  int  rx_stall_pct  = 52;
  bit  hold_req      = 0;
  int  hold_left     = 0;
  int  cycles        = 0;
  int  requests_sent = 0;
  int  starts_sent   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      dk_sb.check_word(out_ch.result_word, out_ch.word_index, out_ch.last_word);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send(logic [1:0] mode, logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    dk_sb.note_request(mode, b);
    requests_sent++;
    if (mode == pbkdf_pkg::MODE_START) starts_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (dk_sb.words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_apply(logic [31:0] pwl, logic [31:0] sl, logic [31:0] it);
    cfg_we <= 1'b1; cfg_index <= pbkdf_pkg::CFG_PW_LEN;   cfg_data <= pwl;
    dk_sb.set_reg(pbkdf_pkg::CFG_PW_LEN, pwl);
    @(negedge clk);
    cfg_index <= pbkdf_pkg::CFG_SALT_LEN; cfg_data <= sl;
    dk_sb.set_reg(pbkdf_pkg::CFG_SALT_LEN, sl);
    @(negedge clk);
    cfg_index <= pbkdf_pkg::CFG_ITER; cfg_data <= it;
    dk_sb.set_reg(pbkdf_pkg::CFG_ITER, it);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // interleaved password and salt bytes, optional unused-mode noise, then start
  task automatic stream_and_start(int npw, int ns, bit noise);
    int left_pw, left_s;
    left_pw = npw;
    left_s  = ns;
    while (left_pw + left_s > 0) begin
      if (noise && $urandom_range(15) == 0) send(MODE_UNUSED, 8'($urandom));
      if ($urandom_range(left_pw + left_s - 1) < left_pw) begin
        send(pbkdf_pkg::MODE_PW, 8'($urandom));
        left_pw--;
      end else begin
        send(pbkdf_pkg::MODE_SALT, 8'($urandom));
        left_s--;
      end
    end
    send(pbkdf_pkg::MODE_START, 8'($urandom));
  endtask

  task automatic session(int pwl, int sl, int it, int npw, int ns, bit noise);
    wait_idle();
    cfg_apply(pwl, sl, it);
    stream_and_start(npw, ns, noise);
  endtask

  initial begin
    int pwl, sl, it;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = pbkdf_pkg::CFG_PW_LEN;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = pbkdf_pkg::MODE_PW;
    in_ch.data_byte = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, surplus bytes, unused mode, zero lengths and iterations
    cfg_apply(3, 4, 1);
    send(pbkdf_pkg::MODE_PW, 8'h00); send(pbkdf_pkg::MODE_SALT, 8'h00);
    send(pbkdf_pkg::MODE_PW, 8'hff); send(pbkdf_pkg::MODE_SALT, 8'hff);
    send(pbkdf_pkg::MODE_PW, 8'h80); send(pbkdf_pkg::MODE_SALT, 8'h01);
    send(pbkdf_pkg::MODE_SALT, 8'h7f); send(pbkdf_pkg::MODE_PW, 8'h55);
    send(pbkdf_pkg::MODE_SALT, 8'haa);
    send(MODE_UNUSED, 8'hff); send(pbkdf_pkg::MODE_START, 8'h00);
    wait_idle();
    cfg_apply(0, 0, 0);
    send(pbkdf_pkg::MODE_START, 8'hff);
    wait_idle();
    cfg_apply(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    cfg_apply(2, 1, 2);
    send(pbkdf_pkg::MODE_PW, 8'h5a); send(pbkdf_pkg::MODE_SALT, 8'hc3);
    send(pbkdf_pkg::MODE_PW, 8'h3c); send(pbkdf_pkg::MODE_START, 8'h00);

    // pressure: results held back while a second request set queues behind the first
    wait_idle();
    cfg_apply(1, 1, 3);
    hold_req = 1;
    send(pbkdf_pkg::MODE_PW, 8'h11); send(pbkdf_pkg::MODE_SALT, 8'h22);
    send(pbkdf_pkg::MODE_START, 8'h00);
    send(pbkdf_pkg::MODE_PW, 8'h33); send(pbkdf_pkg::MODE_SALT, 8'h44);
    send(pbkdf_pkg::MODE_START, 8'h00);

    // long password: a full block is hashed and the digest becomes the key
    wait_idle();
    send_gap_pct = 52; rx_stall_pct = 29;
    session(129, 0, 1, 129, 0, 1'b0);

    // short sessions with no send gaps or result stalls, one with an oversized salt length
    wait_idle();
    send_gap_pct = 0; rx_stall_pct = 0;
    session(2, 200, 2, 2, 3, 1'b1);
    pwl = $urandom_range(3);
    sl  = $urandom_range(3);
    it  = $urandom_range(3);
    session(pwl, sl, it, pwl, sl, 1'b1);

    wait_idle();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d requests, %0d derivations, %0d result words checked",
             requests_sent, starts_sent, dk_sb.words_seen);
    $display("short and hashed passwords, surplus bytes, zero and small iteration counts");
    if (dk_sb.errors == 0 && dk_sb.words_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d words outstanding", dk_sb.errors, dk_sb.words_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/pbkdf_pkg.sv
src/pbkdf_ifs.sv
src/pbkdf_sha_core.sv
src/pbkdf_dp.sv
src/pbkdf_ctrl.sv
src/pbkdf2_hmac_sha512_engine.sv
sim/pbkdf_tb_ifs.sv
sim/tb.sv
